@@ hw/rtl/nad_pkg.sv @@
// ----------------------------------------------------------------------------
// nad_pkg
// Types, codes and constant tables shared by the number-to-ASCII blocks.
// ----------------------------------------------------------------------------
package nad_pkg;

	typedef enum logic [2:0] {
		CMD_HEX8  = 3'd0,
		CMD_HEX16 = 3'd1,
		CMD_HEX32 = 3'd2,
		CMD_DEC16 = 3'd3,
		CMD_DEC32 = 3'd4
	} cmd_t;

	localparam int QUEUE_DEPTH_DEF = 2;

	// first digit index of each format (digits - 1 for hex, top exponent for decimal)
	localparam logic [3:0] HEX8_TOP  = 4'd1;
	localparam logic [3:0] HEX16_TOP = 4'd3;
	localparam logic [3:0] HEX32_TOP = 4'd7;
	localparam logic [3:0] DEC16_TOP = 4'd4;
	localparam logic [3:0] DEC32_TOP = 4'd9;

	localparam logic [7:0] ASCII_0  = 8'h30;
	localparam logic [7:0] ASCII_9  = 8'h39;
	localparam logic [7:0] ASCII_A  = 8'h61;
	localparam logic [7:0] ASCII_F  = 8'h66;
	localparam logic [3:0] HEX_TEN  = 4'h a;

	// one request for the back end
	typedef struct packed {
		logic        dec;
		logic [3:0]  cnt;
		logic [31:0] value;
	} job_t;

	// k * 10^e for k = 1..9, rows past 10^9 unused
	typedef logic [8:0][33:0] dec_row_t;
	typedef dec_row_t [15:0] dec_tab_t;

	function automatic dec_tab_t build_dec_tab();
		dec_tab_t    t;
		logic [63:0] p;
		logic [63:0] m;
		t = '0;
		p = 64'd1;
		for (int e = 0; e < 16; e++) begin
			for (int k = 1; k < 10; k++) begin
				m = p * 64'(k);
				if (e < 10) begin
					t[e][k-1] = m[33:0];
				end
			end
			p = p * 64'd10;
		end
		return t;
	endfunction

	localparam dec_tab_t DEC_MULT = build_dec_tab();

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < HEX_TEN) begin
			return ASCII_0 + {4'b0, nib};
		end
		return ASCII_A + {4'b0, nib - HEX_TEN};
	endfunction

endpackage

@@ hw/rtl/nad_cmd_if.sv @@
// ----------------------------------------------------------------------------
// nad_cmd_if
// Number request channel: format command and value.
// ----------------------------------------------------------------------------
interface nad_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [31:0] value;

	modport source(output valid, output command, output value, input ready);
	modport sink(input valid, input command, input value, output ready);
endinterface

@@ hw/rtl/nad_char_if.sv @@
// ----------------------------------------------------------------------------
// nad_char_if
// Character request channel: one ASCII character and end-of-number mark.
// ----------------------------------------------------------------------------
interface nad_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source(output valid, output character, output last, input ready);
	modport sink(input valid, input character, input last, output ready);
endinterface

@@ hw/rtl/nad_front.sv @@
// ----------------------------------------------------------------------------
// nad_front
// Accepts number requests, drops unknown formats, masks and aligns the value.
// ----------------------------------------------------------------------------
module nad_front (
	nad_cmd_if.sink         cmd_ch,
	input  logic            q_ready,
	output logic            push,
	output nad_pkg::job_t   job
);
	import nad_pkg::*;

	logic known;

	assign cmd_ch.ready = q_ready;

	always_comb begin
		known     = 1'b1;
		job.dec   = 1'b0;
		job.cnt   = HEX32_TOP;
		job.value = cmd_ch.value;
		case (cmd_t'(cmd_ch.command))
			CMD_HEX8: begin
				job.cnt   = HEX8_TOP;
				job.value = {cmd_ch.value[7:0], 24'b0};
			end
			CMD_HEX16: begin
				job.cnt   = HEX16_TOP;
				job.value = {cmd_ch.value[15:0], 16'b0};
			end
			CMD_HEX32: begin
				job.cnt   = HEX32_TOP;
			end
			CMD_DEC16: begin
				job.dec   = 1'b1;
				job.cnt   = DEC16_TOP;
				job.value = {16'b0, cmd_ch.value[15:0]};
			end
			CMD_DEC32: begin
				job.dec   = 1'b1;
				job.cnt   = DEC32_TOP;
			end
			default: begin
				known     = 1'b0;
			end
		endcase
	end

	assign push = cmd_ch.valid && q_ready && known;

endmodule

@@ hw/rtl/nad_queue.sv @@
// ----------------------------------------------------------------------------
// nad_queue
// Small first-in first-out queue of requests between front and back end.
// ----------------------------------------------------------------------------
module nad_queue #(
	parameter int DEPTH = nad_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  nad_pkg::job_t   push_job,
	output logic            ready,
	input  logic            pop,
	output logic            valid,
	output nad_pkg::job_t   pop_job
);
	import nad_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign ready   = cnt_q != CW'(DEPTH);
	assign valid   = cnt_q != '0;
	assign pop_job = mem_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/nad_back.sv @@
// ----------------------------------------------------------------------------
// nad_back
// Digit engine: one hex nibble or one decimal digit per cycle while the
// character output accepts, MSB first, into an output register.
// ----------------------------------------------------------------------------
module nad_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  nad_pkg::job_t   q_job,
	output logic            pop,
	nad_char_if.source      char_ch
);
	import nad_pkg::*;

	logic        busy_q;
	logic        dec_q;
	logic [3:0]  cnt_q;
	logic [31:0] val_q;
	logic        begun_q;
	logic        out_valid_q;
	logic [7:0]  char_q;
	logic        last_q;

	logic        adv;
	logic        step;
	logic        done;
	logic        emit;
	logic [34:0] diff [9];
	logic [8:0]  ge;
	logic [3:0]  digit;
	logic [31:0] rem;
	logic [7:0]  ch;

	// decimal digit: all nine trial subtractions in parallel
	always_comb begin
		digit = '0;
		rem   = val_q;
		for (int k = 0; k < 9; k++) begin
			diff[k] = {3'b0, val_q} - {1'b0, DEC_MULT[cnt_q][k]};
			ge[k]   = !diff[k][34];
			if (ge[k]) begin
				digit = 4'(k + 1);
				rem   = diff[k][31:0];
			end
		end
	end

	assign adv  = !out_valid_q || char_ch.ready;
	assign step = busy_q && adv;
	assign done = cnt_q == '0;
	assign emit = !dec_q || digit != '0 || begun_q || done;
	assign ch   = dec_q ? ASCII_0 + {4'b0, digit} : hex_char(val_q[31:28]);
	assign pop  = q_valid && (!busy_q || (step && done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (step && done) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= step && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dec_q   <= q_job.dec;
			cnt_q   <= q_job.cnt;
			val_q   <= q_job.value;
			begun_q <= 1'b0;
		end else if (step) begin
			cnt_q   <= cnt_q - 1'b1;
			val_q   <= dec_q ? rem : {val_q[27:0], 4'b0};
			begun_q <= begun_q || emit;
		end
		if (adv) begin
			char_q <= ch;
			last_q <= done;
		end
	end

	assign char_ch.valid     = out_valid_q;
	assign char_ch.character = char_q;
	assign char_ch.last      = last_q;

endmodule

@@ hw/rtl/number_to_ascii_digits.sv @@
// ----------------------------------------------------------------------------
// number_to_ascii_digits
// Converts a number to lower-case hex or leading-zero-suppressed decimal
// ASCII characters, most significant first, last character marked.
// ----------------------------------------------------------------------------
// Each accepted request runs through the digit engine at one digit position
// per cycle while the character output accepts: 2, 4 or 8 positions for the
// hex formats, and 5 (16-bit) or 10 (32-bit) positions for decimal whatever
// the number of leading zeros, since the engine walks every power of ten.
// The next request starts in the cycle after the last position. Unknown
// formats are dropped at the input and never reach the engine. A short queue
// lets new requests be taken while the engine or the character output is
// stalled.
module number_to_ascii_digits #(
	parameter int QUEUE_DEPTH = nad_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	nad_cmd_if.sink     cmd_ch,
	nad_char_if.source  char_ch
);
	import nad_pkg::*;

	logic push;
	job_t push_job;
	logic q_ready;
	logic q_valid;
	logic pop;
	job_t pop_job;

	nad_front u_front (
		.cmd_ch  (cmd_ch),
		.q_ready (q_ready),
		.push    (push),
		.job     (push_job)
	);

	nad_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.ready    (q_ready),
		.pop      (pop),
		.valid    (q_valid),
		.pop_job  (pop_job)
	);

	nad_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_job   (pop_job),
		.pop     (pop),
		.char_ch (char_ch)
	);

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> cmd_ch.ready)
		else $error("queue empty but requests refused");

	a_job_shape: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_job.dec && (push_job.cnt == DEC16_TOP || push_job.cnt == DEC32_TOP)) ||
			(!push_job.dec && (push_job.cnt == HEX8_TOP || push_job.cnt == HEX16_TOP ||
			push_job.cnt == HEX32_TOP)))
		else $error("bad job digit count");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_ch.valid |-> (char_ch.character >= ASCII_0 && char_ch.character <= ASCII_9) ||
			(char_ch.character >= ASCII_A && char_ch.character <= ASCII_F))
		else $error("character out of digit range");

endmodule
